// ===== design/cau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned FRAC_W = 8;
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned VAL_W  = PROD_W + 1 - FRAC_W;
  localparam int unsigned NUM_W  = PROD_W + FRAC_W;
  localparam int unsigned DEN_W  = PROD_W;
  localparam int unsigned Q_W    = DATA_W + 1;
  localparam int unsigned CMP_W  = NUM_W + Q_W;

  typedef struct packed {
    logic                    valid;
    logic                    is_div;
    logic                    dz;
    logic                    neg_re;
    logic                    neg_im;
    logic                    ovf_re;
    logic                    ovf_im;
    logic signed [VAL_W-1:0] val_re;
    logic signed [VAL_W-1:0] val_im;
    logic [NUM_W-1:0]        rem_re;
    logic [NUM_W-1:0]        rem_im;
    logic [DEN_W-1:0]        den;
    logic [Q_W-1:0]          q_re;
    logic [Q_W-1:0]          q_im;
  } stage_t;

endpackage

`default_nettype wire

// ===== design/cau_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface cau_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic signed [15:0]       a_re;
  logic signed [15:0]       a_im;
  logic signed [15:0]       b_re;
  logic signed [15:0]       b_im;

  modport source (output valid, op, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, op, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] res_re;
  logic signed [15:0] res_im;
  logic               saturated;
  logic               div_by_zero;

  modport source (output valid, res_re, res_im, saturated, div_by_zero, input ready);
  modport sink   (input valid, res_re, res_im, saturated, div_by_zero, output ready);
endinterface

`default_nettype wire

// ===== design/complex_arith_unit.sv =====
// channel  dir  payload                          handshake
// in_ch    in   op, a_re, a_im, b_re, b_im       valid / ready
// out_ch   out  res_re, res_im, saturated,       valid / ready
//               div_by_zero
// one word per cycle while out_ch is not stalled; every op takes the same path from input to output
// the 17-stage restoring divider works out one quotient bit a stage
// reset clears the valid bits only; in_ch.ready is high right after reset
// a stall at out_ch freezes every stage together, in_ch.ready follows it
`timescale 1ns / 1ps
`default_nettype none

module complex_arith_unit (
  input  logic      clk,
  input  logic      rst_n,
  cau_in_if.sink    in_ch,
  cau_out_if.source out_ch
);

  logic            en;
  logic            out_valid_r;
  cau_pkg::stage_t front_st;
  cau_pkg::stage_t div_st;

  assign en           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = out_valid_r;

  cau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_a_re  (in_ch.a_re),
    .in_a_im  (in_ch.a_im),
    .in_b_re  (in_ch.b_re),
    .in_b_im  (in_ch.b_im),
    .st_r     (front_st)
  );

  cau_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .st_in  (front_st),
    .st_out (div_st)
  );

  cau_sat u_sat (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .st_in       (div_st),
    .out_valid_r (out_valid_r),
    .res_re_r    (out_ch.res_re),
    .res_im_r    (out_ch.res_im),
    .sat_r       (out_ch.saturated),
    .dz_r        (out_ch.div_by_zero)
  );

endmodule

`default_nettype wire

// ===== design/cau_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cau_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [1:0]                        in_op,
  input  logic signed [cau_pkg::DATA_W-1:0] in_a_re,
  input  logic signed [cau_pkg::DATA_W-1:0] in_a_im,
  input  logic signed [cau_pkg::DATA_W-1:0] in_b_re,
  input  logic signed [cau_pkg::DATA_W-1:0] in_b_im,
  output cau_pkg::stage_t                   st_r
);

  localparam int unsigned PW = cau_pkg::PROD_W;
  localparam int unsigned DW = cau_pkg::DATA_W;
  localparam int unsigned VW = cau_pkg::VAL_W;
  localparam int unsigned FW = cau_pkg::FRAC_W;

  logic                 v1_r;
  cau_pkg::op_t         op1_r;
  logic signed [DW-1:0] ar1_r, ai1_r, br1_r, bi1_r;
  logic signed [PW-1:0] prr_r, pii_r, pri_r, pir_r, sqr_r, sqi_r;

  // products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      op1_r <= cau_pkg::op_t'(in_op);
      ar1_r <= in_a_re;
      ai1_r <= in_a_im;
      br1_r <= in_b_re;
      bi1_r <= in_b_im;
      prr_r <= in_a_re * in_b_re;
      pii_r <= in_a_im * in_b_im;
      pri_r <= in_a_re * in_b_im;
      pir_r <= in_a_im * in_b_re;
      sqr_r <= in_b_re * in_b_re;
      sqi_r <= in_b_im * in_b_im;
    end
  end

  // sums, shift and magnitudes
  cau_pkg::stage_t      st_nxt;
  logic signed [PW:0]   mre, mim, nre, nim;
  logic [PW:0]          mag_re, mag_im;
  logic signed [DW:0]   s_re, s_im;

  always_comb begin
    mre    = (PW+1)'(prr_r) - (PW+1)'(pii_r);
    mim    = (PW+1)'(pri_r) + (PW+1)'(pir_r);
    nre    = (PW+1)'(prr_r) + (PW+1)'(pii_r);
    nim    = (PW+1)'(pir_r) - (PW+1)'(pri_r);
    mag_re = nre[PW] ? -nre : nre;
    mag_im = nim[PW] ? -nim : nim;
    s_re   = (op1_r == cau_pkg::OP_SUB) ? (DW+1)'(ar1_r) - (DW+1)'(br1_r)
                                        : (DW+1)'(ar1_r) + (DW+1)'(br1_r);
    s_im   = (op1_r == cau_pkg::OP_SUB) ? (DW+1)'(ai1_r) - (DW+1)'(bi1_r)
                                        : (DW+1)'(ai1_r) + (DW+1)'(bi1_r);
    st_nxt        = '0;
    st_nxt.valid  = v1_r;
    st_nxt.is_div = (op1_r == cau_pkg::OP_DIV);
    st_nxt.den    = PW'(sqr_r) + PW'(sqi_r);
    st_nxt.dz     = st_nxt.is_div && (st_nxt.den == '0);
    st_nxt.neg_re = nre[PW];
    st_nxt.neg_im = nim[PW];
    st_nxt.rem_re = {mag_re[PW-1:0], FW'(0)};
    st_nxt.rem_im = {mag_im[PW-1:0], FW'(0)};
    case (op1_r)
      cau_pkg::OP_MUL: begin
        st_nxt.val_re = mre[PW:FW];
        st_nxt.val_im = mim[PW:FW];
      end
      default: begin
        st_nxt.val_re = VW'(s_re);
        st_nxt.val_im = VW'(s_im);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/cau_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cau_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  cau_pkg::stage_t st_in,
  output cau_pkg::stage_t st_out
);

  localparam int unsigned QW = cau_pkg::Q_W;
  localparam int unsigned NW = cau_pkg::NUM_W;
  localparam int unsigned CW = cau_pkg::CMP_W;

  cau_pkg::stage_t dv_r [QW+1];
  cau_pkg::stage_t first_nxt;
  logic [CW-1:0]   den_top;

  // quotient wider than 17 bits always clamps, unless the divisor is zero
  always_comb begin
    den_top          = CW'(st_in.den) << QW;
    first_nxt        = st_in;
    first_nxt.ovf_re = CW'(st_in.rem_re) >= den_top;
    first_nxt.ovf_im = CW'(st_in.rem_im) >= den_top;
    first_nxt.q_re   = '0;
    first_nxt.q_im   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0].valid <= 1'b0;
    end else if (en) begin
      dv_r[0] <= first_nxt;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar i = 0; i < QW; i++) begin : g_step
    localparam int unsigned K = QW - 1 - i;
    cau_pkg::stage_t step_nxt;
    logic [CW-1:0]   sh;

    always_comb begin
      sh       = CW'(dv_r[i].den) << K;
      step_nxt = dv_r[i];
      if (CW'(dv_r[i].rem_re) >= sh) begin
        step_nxt.rem_re  = dv_r[i].rem_re - sh[NW-1:0];
        step_nxt.q_re[K] = 1'b1;
      end
      if (CW'(dv_r[i].rem_im) >= sh) begin
        step_nxt.rem_im  = dv_r[i].rem_im - sh[NW-1:0];
        step_nxt.q_im[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[i+1].valid <= 1'b0;
      end else if (en) begin
        dv_r[i+1] <= step_nxt;
      end
    end
  end

  assign st_out = dv_r[QW];

endmodule

`default_nettype wire

// ===== design/cau_sat.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cau_sat (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  cau_pkg::stage_t                   st_in,
  output logic                              out_valid_r,
  output logic signed [cau_pkg::DATA_W-1:0] res_re_r,
  output logic signed [cau_pkg::DATA_W-1:0] res_im_r,
  output logic                              sat_r,
  output logic                              dz_r
);

  localparam int unsigned DW = cau_pkg::DATA_W;
  localparam int unsigned VW = cau_pkg::VAL_W;
  localparam int unsigned QW = cau_pkg::Q_W;
  localparam logic signed [VW-1:0] VMAX = VW'((1 << (DW - 1)) - 1);
  localparam logic signed [VW-1:0] VMIN = -VW'(1 << (DW - 1));

  logic signed [VW-1:0] v_re, v_im;
  logic                 sat_re, sat_im;
  logic signed [DW-1:0] res_re_nxt, res_im_nxt;

  function automatic logic signed [VW-1:0] div_val(input logic neg, input logic ovf,
                                                   input logic [QW-1:0] q);
    logic signed [VW-1:0] m;
    m = VW'(q);
    if (ovf) begin
      m = neg ? VMIN - VW'(1) : VMAX + VW'(1);
    end else if (neg) begin
      m = -m;
    end
    return m;
  endfunction

  always_comb begin
    if (st_in.dz) begin
      v_re = '0;
      v_im = '0;
    end else if (st_in.is_div) begin
      v_re = div_val(st_in.neg_re, st_in.ovf_re, st_in.q_re);
      v_im = div_val(st_in.neg_im, st_in.ovf_im, st_in.q_im);
    end else begin
      v_re = st_in.val_re;
      v_im = st_in.val_im;
    end
    sat_re     = (v_re > VMAX) || (v_re < VMIN);
    sat_im     = (v_im > VMAX) || (v_im < VMIN);
    res_re_nxt = (v_re > VMAX) ? DW'(VMAX) : (v_re < VMIN) ? DW'(VMIN) : DW'(v_re);
    res_im_nxt = (v_im > VMAX) ? DW'(VMAX) : (v_im < VMIN) ? DW'(VMIN) : DW'(v_im);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= st_in.valid;
    end
    if (en) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      sat_r    <= sat_re || sat_im;
      dz_r     <= st_in.dz;
    end
  end

endmodule

`default_nettype wire

// ===== design/cau_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cau_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] res_re,
  input logic [15:0] res_im,
  input logic        saturated,
  input logic        div_by_zero
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_re) && $stable(res_im))
    else $error("output word changed under stall");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (out_ready || !out_valid))
    else $error("input ready does not follow output stall");

  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && div_by_zero |-> res_re == 16'h0 && res_im == 16'h0 && !saturated)
    else $error("zero divisor word not cleared");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .res_re      (out_ch.res_re),
  .res_im      (out_ch.res_im),
  .saturated   (out_ch.saturated),
  .div_by_zero (out_ch.div_by_zero)
);

`default_nettype wire
